### sv/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg - shared types and constants of the HTTP request tokenizer
// Phase encoding, field tags, error codes, character codes and the result
// record passed from the classifier to the output queue.
// ----------------------------------------------------------------------------
package hrt_pkg;

	// Parse phase within one request.
	typedef enum logic [2:0] {
		PH_METHOD,
		PH_URI,
		PH_VERSION,
		PH_HNAME,
		PH_HSKIP,
		PH_HVALUE,
		PH_BODY,
		PH_ERR
	} phase_t;

	// Field tags.
	localparam logic [2:0] TAG_METHOD = 3'd0;
	localparam logic [2:0] TAG_URI    = 3'd1;
	localparam logic [2:0] TAG_VER    = 3'd2;
	localparam logic [2:0] TAG_HNAME  = 3'd3;
	localparam logic [2:0] TAG_HVALUE = 3'd4;
	localparam logic [2:0] TAG_BODY   = 3'd5;
	localparam logic [2:0] TAG_DELIM  = 3'd6;

	// Error codes, sticky within a request.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NO_CRLF   = 2'd1;
	localparam logic [1:0] ERR_NO_METHOD = 2'd2;
	localparam logic [1:0] ERR_NO_URI    = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Parser state carried from byte to byte.
	typedef struct packed {
		phase_t     phase;
		logic       cr_held;
		logic       line_empty;
		logic       colon_seen;
		logic [1:0] error_seen;
	} tok_state_t;

	localparam tok_state_t STATE_RESET = '{
		phase:      PH_METHOD,
		cr_held:    1'b0,
		line_empty: 1'b1,
		colon_seen: 1'b0,
		error_seen: ERR_NONE
	};

	// One classified output beat.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] tag;
		logic       line_done;
		logic       kept;
		logic [1:0] err;
		logic       req_done;
		logic       last;
	} tok_result_t;

	// State and result produced by one classification step.
	typedef struct packed {
		tok_state_t  st;
		tok_result_t res;
	} step_t;

endpackage

### sv/hrt_step.sv
// ----------------------------------------------------------------------------
// hrt_step - single-byte classifier
// Takes the current parser state and one input byte and produces up to two
// classified results together with the next parser state.
// ----------------------------------------------------------------------------
module hrt_step (
	input  hrt_pkg::tok_state_t  state,
	input  logic [7:0]           data,
	input  logic                 eor,
	output hrt_pkg::tok_state_t  state_next,
	output hrt_pkg::tok_result_t res0,
	output hrt_pkg::tok_result_t res1,
	output logic                 v0,
	output logic                 v1
);
	import hrt_pkg::*;

	// Classify one ordinary content byte.
	function automatic step_t do_content(tok_state_t s, logic [7:0] b);
		step_t o;
		o = '0;
		o.st = s;
		o.res.data = b;
		o.res.tag = TAG_DELIM;
		case (s.phase)
			PH_METHOD: begin
				if (b == CH_SP) o.st.phase = PH_URI;
				else o.res.tag = TAG_METHOD;
			end
			PH_URI: begin
				if (b == CH_SP) o.st.phase = PH_VERSION;
				else o.res.tag = TAG_URI;
			end
			PH_VERSION: o.res.tag = TAG_VER;
			PH_HNAME: begin
				o.st.line_empty = 1'b0;
				if (b == CH_COLON) begin
					o.st.colon_seen = 1'b1;
					o.st.phase = PH_HSKIP;
				end else begin
					o.res.tag = TAG_HNAME;
				end
			end
			PH_HSKIP: begin
				o.st.line_empty = 1'b0;
				if (b != CH_SP) begin
					o.res.tag = TAG_HVALUE;
					o.st.phase = PH_HVALUE;
				end
			end
			PH_HVALUE: o.res.tag = TAG_HVALUE;
			PH_BODY: o.res.tag = TAG_BODY;
			default: o.res.tag = TAG_DELIM;
		endcase
		o.res.err = o.st.error_seen;
		return o;
	endfunction

	// Close a line on a CRLF pair; b is the LF.
	function automatic step_t do_line_end(tok_state_t s, logic [7:0] b);
		step_t o;
		o = '0;
		o.st = s;
		o.res.data = b;
		o.res.tag = TAG_DELIM;
		case (s.phase)
			PH_METHOD, PH_URI: begin
				if (s.error_seen == ERR_NONE)
					o.st.error_seen = (s.phase == PH_METHOD) ? ERR_NO_METHOD : ERR_NO_URI;
				o.st.phase = PH_ERR;
				o.res.line_done = 1'b1;
			end
			PH_VERSION: begin
				o.st.phase = PH_HNAME;
				o.st.line_empty = 1'b1;
				o.st.colon_seen = 1'b0;
				o.res.line_done = 1'b1;
			end
			PH_HNAME, PH_HSKIP, PH_HVALUE: begin
				if (s.line_empty) begin
					o.st.phase = PH_BODY;
				end else begin
					o.res.line_done = 1'b1;
					o.res.kept = s.colon_seen;
					o.st.phase = PH_HNAME;
					o.st.line_empty = 1'b1;
					o.st.colon_seen = 1'b0;
				end
			end
			default: o.st.phase = s.phase;
		endcase
		o.res.err = o.st.error_seen;
		return o;
	endfunction

	// Held CR first, then the current byte, then end-of-request fixups.
	always_comb begin
		tok_state_t  st;
		tok_result_t r0;
		tok_result_t r1;
		tok_result_t lr;
		step_t       t;
		logic        consumed;
		logic        n0;
		logic        n1;

		st = state;
		r0 = '0;
		r1 = '0;
		lr = '0;
		t = '0;
		consumed = 1'b0;
		n0 = 1'b0;
		n1 = 1'b0;

		if (st.cr_held) begin
			st.cr_held = 1'b0;
			if (data == CH_LF) begin
				t = do_line_end(st, data);
				consumed = 1'b1;
			end else begin
				t = do_content(st, CH_CR);
			end
			st = t.st;
			r0 = t.res;
			n0 = 1'b1;
		end

		if (!consumed) begin
			if (data == CH_CR && !eor && st.phase != PH_BODY && st.phase != PH_ERR) begin
				st.cr_held = 1'b1;
			end else begin
				t = do_content(st, data);
				st = t.st;
				if (n0) begin
					r1 = t.res;
					n1 = 1'b1;
				end else begin
					r0 = t.res;
					n0 = 1'b1;
				end
			end
		end

		// The final beat of a request carries the closing flags.
		if (eor && n0) begin
			lr = n1 ? r1 : r0;
			if (st.phase == PH_METHOD || st.phase == PH_URI || st.phase == PH_VERSION) begin
				if (st.error_seen == ERR_NONE) st.error_seen = ERR_NO_CRLF;
			end else if ((st.phase == PH_HNAME || st.phase == PH_HSKIP ||
					st.phase == PH_HVALUE) && !st.line_empty) begin
				lr.line_done = 1'b1;
				lr.kept = st.colon_seen;
			end
			lr.err = st.error_seen;
			lr.req_done = 1'b1;
			if (n1) r1 = lr;
			else r0 = lr;
			st = STATE_RESET;
		end

		r0.last = !n1;
		r1.last = 1'b1;

		state_next = st;
		res0 = r0;
		res1 = r1;
		v0 = n0;
		v1 = n1;
	end

endmodule

### sv/http_request_tokenizer_top.sv
// ----------------------------------------------------------------------------
// http_request_tokenizer_top - HTTP/1.1 request byte tokenizer
// Tags each request byte by field, marks line ends and request-line faults.
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, in_byte,              | input
//           | end_of_request                            |
//   out     | out_valid, out_ready, out_byte, field_tag,| output
//           | line_done, header_kept, error_code,       |
//           | request_done, last_of_run                 |
//
// One input byte per cycle is sustained while the output queue has room; an
// accepted input beat passes the input register and the output queue before it leaves.
// A lone CR followed by a non-LF byte yields two output beats for one input
// beat; the four-entry output queue drains one beat per cycle while out_ready is high.
// The input stage advances only when the queue has room for two beats.
// Reset clears the parser state, the input stage and the queue.
// ----------------------------------------------------------------------------
module http_request_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_request,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] field_tag,
	output logic       line_done,
	output logic       header_kept,
	output logic [1:0] error_code,
	output logic       request_done,
	output logic       last_of_run
);
	import hrt_pkg::*;

	localparam int QDEPTH = 4;
	localparam int PW = $clog2(QDEPTH);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eor_s1;
	logic        fire_s1;
	tok_state_t  state_q;
	tok_state_t  state_next;
	tok_result_t res0;
	tok_result_t res1;
	logic        v0;
	logic        v1;

	tok_result_t       queue_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              pop;
	logic [PW:0]       push_n;
	tok_result_t       head;

	// The input stage moves on when the queue can take two beats.
	assign fire_s1 = valid_s1 && (count_q <= (PW+1)'(QDEPTH - 2));
	assign in_ready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_byte;
			eor_s1 <= end_of_request;
		end
	end

	// Classifier.
	hrt_step u_step (
		.state      (state_q),
		.data       (data_s1),
		.eor        (eor_s1),
		.state_next (state_next),
		.res0       (res0),
		.res1       (res1),
		.v0         (v0),
		.v1         (v1)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	// Output queue control.
	assign pop = out_valid && out_ready;
	assign push_n = fire_s1 ? ((PW+1)'(v0) + (PW+1)'(v1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PW-1:0];
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + push_n - (PW+1)'(pop);
		end
	end

	// Output queue storage.
	always_ff @(posedge clk) begin
		if (fire_s1 && v0) queue_q[wr_ptr_q] <= res0;
		if (fire_s1 && v1) queue_q[wr_ptr_q + PW'(1)] <= res1;
	end

	// Output beat.
	assign head = queue_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign out_byte = head.data;
	assign field_tag = head.tag;
	assign line_done = head.line_done;
	assign header_kept = head.kept;
	assign error_code = head.err;
	assign request_done = head.req_done;
	assign last_of_run = head.last;

endmodule

### sv/hrt_checker.sv
// ----------------------------------------------------------------------------
// hrt_checker - port-level checks for the request tokenizer
// Watches both channels and the relations between result flags.
// ----------------------------------------------------------------------------
module hrt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       end_of_request,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [2:0] field_tag,
	input logic       line_done,
	input logic       header_kept,
	input logic [1:0] error_code,
	input logic       request_done,
	input logic       last_of_run
);
	import hrt_pkg::*;

	// A stalled input beat stays offered with the same payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(end_of_request))
		else $error("input beat changed while stalled");

	// A stalled output beat stays offered with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(field_tag) &&
			$stable(line_done) && $stable(header_kept) && $stable(error_code) &&
			$stable(request_done) && $stable(last_of_run))
		else $error("output beat dropped or changed while stalled");

	// A kept header is only reported on a closing beat.
	a_kept_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_kept |-> line_done)
		else $error("header_kept without line_done");

	// The final beat of a request closes the run of its input byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_done |-> last_of_run)
		else $error("request_done on a beat that is not last of run");

	// A missing request-line CRLF is only known when the request ends.
	a_crlf_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NO_CRLF |-> request_done)
		else $error("missing CRLF error before end of request");

endmodule

bind http_request_tokenizer_top hrt_checker u_hrt_checker (.*);
